FILE: src/dti_pkg.sv
// ----------------------------------------------------------------------------
// dti_pkg
// Word types and fixed widths shared by the delta-T interpolation table.
// ----------------------------------------------------------------------------
package dti_pkg;

  localparam int KEY_W  = 40;
  localparam int SEC_W  = 32;
  localparam int FRAC_W = 16;
  localparam int CNT_W  = 9;
  localparam int QUO_W  = FRAC_W + 1;
  localparam int DIF_W  = KEY_W + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic [7:0]               entry_index;
    logic signed [KEY_W-1:0]  day_key;
    logic signed [SEC_W-1:0]  entry_seconds;
  } dti_in_t;

  typedef struct packed {
    logic signed [SEC_W-1:0]  delta_seconds;
    logic                     status;
  } dti_out_t;

  typedef struct packed {
    logic             start;
    logic [DIF_W-1:0] num;
    logic [DIF_W-1:0] den;
  } dti_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } dti_div_rsp_t;

endpackage

FILE: src/dti_ram.sv
// ----------------------------------------------------------------------------
// dti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/dti_divider.sv
// ----------------------------------------------------------------------------
// dti_divider
// Restoring divider, one quotient bit a cycle: floor(num * 2^16 / den),
// with num <= den so the quotient fits 17 bits.
// ----------------------------------------------------------------------------
module dti_divider
  import dti_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dti_div_req_t req,
  output dti_div_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [DIF_W:0]   rem_r, rem_nxt;
  logic [DIF_W-1:0] den_r, den_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             ge;
  logic [DIF_W:0]   sub;

  always_comb begin
    ge  = rem_r >= {1'b0, den_r};
    sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(QUO_W - 1);
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      rem_nxt = {sub[DIF_W-1:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("divider busy and done together");
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && quo_r[QUO_W-1] |-> quo_r[QUO_W-2:0] == '0)
    else $error("divider quotient above one");
`endif

endmodule

FILE: src/delta_t_table_interpolator_top.sv
// ----------------------------------------------------------------------------
// delta_t_table_interpolator_top
// Piecewise linear interpolation over a table of ascending (key, seconds)
// pairs held in two synchronous RAMs.
// ----------------------------------------------------------------------------
// A write word stores one entry as it is accepted and gives no result. A query
// word reads the first and last entries in use; a key at or beyond either
// end returns the seconds of that end entry without a search.
// Otherwise the block binary-searches the pair that brackets the key (up to
// eight steps for 256 entries, as each step reads both entries of the pair
// in turn through the one read address that both RAMs share), then runs a
// one-bit-a-cycle divider for its 17 quotient bits, and a multiply and add.
// One word is in work at a time; a finished result waits in the output
// register, and the next one holds until that register is taken.
module delta_t_table_interpolator_top
  import dti_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dti_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dti_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = AW + 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RF   = 4'd1;
  localparam logic [3:0] S_CF   = 4'd2;
  localparam logic [3:0] S_CL   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_CA   = 4'd5;
  localparam logic [3:0] S_CB   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_ADD  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        entries_r;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [AW-1:0]           last_r, last_nxt;
  logic signed [IW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]           c_r, c_nxt;
  logic signed [KEY_W-1:0] k0_r, k0_nxt;
  logic signed [SEC_W-1:0] v0_r, v0_nxt, v1_r, v1_nxt;
  logic signed [SEC_W-1:0] res_r, res_nxt;
  logic                    st_r, st_nxt;
  logic signed [50:0]      prod_r, prod_nxt;
  logic                    out_valid_r, out_valid_nxt;
  dti_out_t                out_r, out_nxt;

  logic                    acc;
  logic                    ram_we;
  logic [AW-1:0]           waddr, raddr;
  logic [KEY_W-1:0]        key_rd;
  logic [SEC_W-1:0]        sec_rd;
  logic signed [KEY_W-1:0] kd;
  logic signed [SEC_W-1:0] vd;
  logic signed [IW-1:0]    mid;
  logic [AW-1:0]           n_last;
  logic signed [DIF_W-1:0] diff_num, diff_den;
  logic signed [SEC_W:0]   dv;
  logic signed [50:0]      shifted;
  dti_div_req_t            dreq;
  dti_div_rsp_t            drsp;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign ram_we   = acc && (in_data.operation == OP_WRITE)
                    && (int'(in_data.entry_index) < TABLE_DEPTH);
  assign waddr    = AW'(in_data.entry_index);
  assign kd       = $signed(key_rd);
  assign vd       = $signed(sec_rd);
  assign mid      = (lo_r + hi_r) >>> 1;

  always_comb begin
    if (int'(entries_r) < 2) begin
      n_last = AW'(1);
    end else if (int'(entries_r) > TABLE_DEPTH) begin
      n_last = AW'(TABLE_DEPTH - 1);
    end else begin
      n_last = AW'(int'(entries_r) - 1);
    end
  end

  always_comb begin
    unique case (state_r)
      S_CF:    raddr = last_r;
      S_CHK:   raddr = mid[AW-1:0];
      S_CA:    raddr = c_r + AW'(1);
      default: raddr = '0;
    endcase
  end

  dti_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(in_data.day_key),
    .raddr(raddr), .rdata(key_rd)
  );

  dti_ram #(.WIDTH(SEC_W), .DEPTH(TABLE_DEPTH)) u_sec_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(in_data.entry_seconds),
    .raddr(raddr), .rdata(sec_rd)
  );

  assign diff_num   = {key_r[KEY_W-1], key_r} - {k0_r[KEY_W-1], k0_r};
  assign diff_den   = {kd[KEY_W-1], kd} - {k0_r[KEY_W-1], k0_r};
  assign dreq.num   = diff_num;
  assign dreq.den   = diff_den;
  assign dreq.start = (state_r == S_CB) && !(key_r > kd) && (kd != k0_r);

  dti_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign dv      = {v1_r[SEC_W-1], v1_r} - {v0_r[SEC_W-1], v0_r};
  assign shifted = prod_r >>> FRAC_W;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    c_nxt         = c_r;
    k0_nxt        = k0_r;
    v0_nxt        = v0_r;
    v1_nxt        = v1_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_data.operation == OP_QUERY) begin
          key_nxt   = in_data.day_key;
          last_nxt  = n_last;
          state_nxt = S_RF;
        end
      end
      S_RF: state_nxt = S_CF;
      S_CF: begin
        if (key_r <= kd) begin
          res_nxt   = vd;
          st_nxt    = 1'b0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CL;
        end
      end
      S_CL: begin
        if (key_r >= kd) begin
          res_nxt   = vd;
          st_nxt    = 1'b0;
          state_nxt = S_OUT;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = $signed({2'b00, last_r}) - IW'(1);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (lo_r > hi_r) begin
          res_nxt   = '0;
          st_nxt    = 1'b1;
          state_nxt = S_OUT;
        end else begin
          c_nxt     = mid[AW-1:0];
          state_nxt = S_CA;
        end
      end
      S_CA: begin
        k0_nxt = kd;
        v0_nxt = vd;
        if (key_r < kd) begin
          hi_nxt    = $signed({2'b00, c_r}) - IW'(1);
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_CB;
        end
      end
      S_CB: begin
        v1_nxt = vd;
        if (key_r > kd) begin
          lo_nxt    = $signed({2'b00, c_r}) + IW'(1);
          state_nxt = S_CHK;
        end else if (kd == k0_r) begin
          res_nxt   = v0_r;
          st_nxt    = 1'b0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          prod_nxt  = 51'($signed({1'b0, drsp.quo}) * dv);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        res_nxt   = v0_r + shifted[SEC_W-1:0];
        st_nxt    = 1'b0;
        state_nxt = S_ADD;
      end
      S_ADD: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.delta_seconds = res_r;
          out_nxt.status        = st_r;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      entries_r   <= CNT_W'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        entries_r <= cfg_wdata;
      end
    end
    key_r  <= key_nxt;
    last_r <= last_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    c_r    <= c_nxt;
    k0_r   <= k0_nxt;
    v0_r   <= v0_nxt;
    v1_r   <= v1_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_query_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_QUERY |=> state_r == S_RF)
    else $error("query word did not start the search");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status |-> out_r.delta_seconds == '0)
    else $error("failed search with non-zero result");
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");
  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CA |-> c_r < last_r)
    else $error("search index past last entry");
`endif

endmodule
